### rtl/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg: shared definitions for the scaled matrix-vector multiply
// Sizes, field widths, command and register codes, and the control bundle
// that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package smv_pkg;

	localparam int unsigned MAX_DIM    = 64;
	localparam int unsigned VALUE_BITS = 16;
	localparam int unsigned FRAC_BITS  = 8;

	localparam int unsigned IDX_W     = $clog2(MAX_DIM);
	localparam int unsigned DIM_W     = 7;
	localparam int unsigned MAT_DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned MAT_AW    = 2 * IDX_W;

	// Dot product accumulator and the product of the shared multiplier.
	localparam int unsigned ACC_W    = 40;
	localparam int unsigned PROD_W   = ACC_W + VALUE_BITS;
	localparam int unsigned SCALED_W = PROD_W - 2 * FRAC_BITS;
	localparam int unsigned OLD_W    = 2 * VALUE_BITS - FRAC_BITS;
	localparam int unsigned SUM_W    = SCALED_W + 1;

	localparam int unsigned CFG_IDX_W = 3;

	// Item kinds.
	localparam logic [1:0] KIND_LOAD_X   = 2'd0;
	localparam logic [1:0] KIND_LOAD_Y   = 2'd1;
	localparam logic [1:0] KIND_LOAD_MAT = 2'd2;
	localparam logic [1:0] KIND_GO       = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 3'd4;

	localparam logic signed [VALUE_BITS-1:0] ALPHA_RESET = 16'sd256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SCALE,
		ST_BETA,
		ST_SUM,
		ST_YREAD,
		ST_YGET,
		ST_EMIT
	} state_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [1:0] {
		OP_MAC,
		OP_ALPHA,
		OP_BETA
	} op_sel_t;

	typedef struct packed {
		logic             go;
		logic [DIM_W-1:0] len_x;
		logic [DIM_W-1:0] len_y;
		logic             empty;
		logic             pipe_busy;
		logic             out_free;
	} status_t;

	typedef struct packed {
		logic             idle;
		op_sel_t          op_sel;
		logic             acc_clr;
		logic             rd_issue;
		logic             cap_scaled;
		logic             cap_sum;
		logic             cap_copy;
		logic             emit;
		logic             last;
		logic [IDX_W-1:0] y_idx;
		logic [IDX_W-1:0] x_idx;
	} ctl_t;

endpackage

### rtl/smv_if.sv
// ----------------------------------------------------------------------------
// smv_if: handshake channels of the scaled matrix-vector multiply
// One channel carries load and go items, the other carries result elements.
// ----------------------------------------------------------------------------
interface smv_item_if import smv_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic [IDX_W-1:0]             vector_index;
	logic [IDX_W-1:0]             matrix_row;
	logic [IDX_W-1:0]             matrix_column;
	logic signed [VALUE_BITS-1:0] element_value;

	modport source (output valid, kind, vector_index, matrix_row, matrix_column,
		element_value, input ready);
	modport sink (input valid, kind, vector_index, matrix_row, matrix_column,
		element_value, output ready);
endinterface

interface smv_result_if import smv_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [IDX_W-1:0]             result_index;
	logic signed [VALUE_BITS-1:0] result_value;
	logic                         last_of_run;

	modport source (output valid, result_index, result_value, last_of_run, input ready);
	modport sink (input valid, result_index, result_value, last_of_run, output ready);
endinterface

### rtl/scaled_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// scaled_matrix_vector_multiply: y = beta*y + alpha*op(A)*x in signed Q8.8
// Load items fill the x, y and matrix stores; a go item computes the updated
// y element by element, writes it back and sends it out in index order.
//
//   Channel   Direction  Payload                                     Transfer
//   item_ch   in         kind, vector_index, matrix_row,             valid & ready
//                        matrix_column, element_value
//   result_ch out        result_index, result_value, last_of_run     valid & ready
//   cfg       in         cfg_wr_en, cfg_index, cfg_wr_data           cfg_wr_en
//
// A go item with a nonempty matrix forms one multiply-accumulate per cycle
// through the single shared multiplier during each dot product. The item
// channel is not ready while a go item is at work. A stalled result channel
// holds the sequencer in its emit step; one finished result waits in the
// output register. Reset clears control state and configuration, not the
// stores.
// ----------------------------------------------------------------------------
module scaled_matrix_vector_multiply import smv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	smv_item_if.sink              item_ch,
	smv_result_if.source          result_ch,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [VALUE_BITS-1:0] cfg_wr_data
);

	// Configuration registers.
	logic                         transpose_q;
	logic [DIM_W-1:0]             rows_q;
	logic [DIM_W-1:0]             cols_q;
	logic signed [VALUE_BITS-1:0] alpha_q;
	logic signed [VALUE_BITS-1:0] beta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= 1'b0;
			rows_q      <= '0;
			cols_q      <= '0;
			alpha_q     <= ALPHA_RESET;
			beta_q      <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TRANSPOSE: transpose_q <= cfg_wr_data[0];
				CFG_ROWS:      rows_q      <= cfg_wr_data[DIM_W-1:0];
				CFG_COLS:      cols_q      <= cfg_wr_data[DIM_W-1:0];
				CFG_ALPHA:     alpha_q     <= cfg_wr_data;
				CFG_BETA:      beta_q      <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	// Counts above the store size are taken as the store size.
	logic [DIM_W-1:0] rows_c;
	logic [DIM_W-1:0] cols_c;

	assign rows_c = (rows_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_q;
	assign cols_c = (cols_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_q;

	// Sequencer.
	status_t sts;
	ctl_t    ctl;
	logic    rd_v_s1;
	logic    mac_v_s2;
	logic    out_valid_q;
	logic    item_xfer;

	assign item_xfer     = item_ch.valid && item_ch.ready;
	assign item_ch.ready = ctl.idle;

	assign sts.go        = item_xfer && (item_ch.kind == KIND_GO);
	assign sts.len_x     = transpose_q ? rows_c : cols_c;
	assign sts.len_y     = transpose_q ? cols_c : rows_c;
	assign sts.empty     = (rows_c == '0) || (cols_c == '0);
	assign sts.pipe_busy = rd_v_s1 || mac_v_s2;
	assign sts.out_free  = !out_valid_q || result_ch.ready;

	smv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// Stores. Loads write while the block is idle; the y store also takes the
	// updated element at each emit.
	logic [VALUE_BITS-1:0] mat_rdata;
	logic [VALUE_BITS-1:0] x_rdata;
	logic [VALUE_BITS-1:0] y_rdata;
	logic [MAT_AW-1:0]     mat_raddr;
	logic                  y_we;
	logic [IDX_W-1:0]      y_waddr;
	logic [VALUE_BITS-1:0] y_wdata;
	logic signed [VALUE_BITS-1:0] res_q;

	// The matrix is stored row major; the transpose swaps the roles of the
	// y and x counters in the address.
	assign mat_raddr = transpose_q ? {ctl.x_idx, ctl.y_idx} : {ctl.y_idx, ctl.x_idx};

	assign y_we    = ctl.emit || (item_xfer && (item_ch.kind == KIND_LOAD_Y));
	assign y_waddr = ctl.emit ? ctl.y_idx : item_ch.vector_index;
	assign y_wdata = ctl.emit ? res_q : item_ch.element_value;

	smv_ram #(
		.DEPTH (MAT_DEPTH),
		.WIDTH (VALUE_BITS)
	) u_mat_ram (
		.clk   (clk),
		.we    (item_xfer && (item_ch.kind == KIND_LOAD_MAT)),
		.waddr ({item_ch.matrix_row, item_ch.matrix_column}),
		.wdata (item_ch.element_value),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	smv_ram #(
		.DEPTH (MAX_DIM),
		.WIDTH (VALUE_BITS)
	) u_x_ram (
		.clk   (clk),
		.we    (item_xfer && (item_ch.kind == KIND_LOAD_X)),
		.waddr (item_ch.vector_index),
		.wdata (item_ch.element_value),
		.raddr (ctl.x_idx),
		.rdata (x_rdata)
	);

	smv_ram #(
		.DEPTH (MAX_DIM),
		.WIDTH (VALUE_BITS)
	) u_y_ram (
		.clk   (clk),
		.we    (y_we),
		.waddr (y_waddr),
		.wdata (y_wdata),
		.raddr (ctl.y_idx),
		.rdata (y_rdata)
	);

	// Shared multiplier. During the dot product it forms matrix times x terms;
	// afterwards it scales the sum by alpha and then the old y by beta.
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [ACC_W-1:0]      mul_a;
	logic signed [VALUE_BITS-1:0] mul_b;
	logic signed [PROD_W-1:0]     prod_q;

	always_comb begin
		case (ctl.op_sel)
			OP_ALPHA: begin
				mul_a = acc_q;
				mul_b = alpha_q;
			end
			OP_BETA: begin
				mul_a = ACC_W'($signed(y_rdata));
				mul_b = beta_q;
			end
			default: begin
				mul_a = ACC_W'($signed(mat_rdata));
				mul_b = $signed(x_rdata);
			end
		endcase
	end

	smv_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// Read data is registered after the address and the product after the read
	// data; the two valid flags follow each term to the accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			mac_v_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			rd_v_s1  <= ctl.rd_issue;
			mac_v_s2 <= rd_v_s1;
			if (ctl.acc_clr) begin
				acc_q <= '0;
			end else if (mac_v_s2) begin
				acc_q <= acc_q + prod_q[ACC_W-1:0];
			end
		end
	end

	// Combine the scaled product with the scaled old y and saturate.
	logic signed [SCALED_W-1:0] scaled_q;
	logic signed [OLD_W-1:0]    old_c;
	logic signed [SUM_W-1:0]    sum_c;
	logic signed [VALUE_BITS-1:0] sat_c;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (VALUE_BITS - 1) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	// A zero beta ignores y in the sum, so an unwritten y store is harmless unless the matrix is empty.
	assign old_c = (beta_q == '0) ? '0 : $signed(prod_q[2*VALUE_BITS-1:FRAC_BITS]);
	assign sum_c = SUM_W'(scaled_q) + SUM_W'(old_c);

	always_comb begin
		if (sum_c > SAT_HI) begin
			sat_c = SAT_HI[VALUE_BITS-1:0];
		end else if (sum_c < SAT_LO) begin
			sat_c = SAT_LO[VALUE_BITS-1:0];
		end else begin
			sat_c = sum_c[VALUE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_scaled) begin
			scaled_q <= prod_q[PROD_W-1:2*FRAC_BITS];
		end
		if (ctl.cap_sum) begin
			res_q <= sat_c;
		end else if (ctl.cap_copy) begin
			res_q <= $signed(y_rdata);
		end
	end

	// Output register.
	logic [IDX_W-1:0]             out_idx_q;
	logic signed [VALUE_BITS-1:0] out_val_q;
	logic                         out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_idx_q  <= ctl.y_idx;
			out_val_q  <= res_q;
			out_last_q <= ctl.last;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.result_index = out_idx_q;
	assign result_ch.result_value = out_val_q;
	assign result_ch.last_of_run  = out_last_q;

	// No multiply-accumulate term may still be in flight while items are taken.
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		item_ch.ready |-> !(rd_v_s1 || mac_v_s2))
		else $error("item channel ready with dot product terms in flight");

	// Only matrix times x products may reach the accumulator.
	a_acc_from_mac: assert property (@(posedge clk) disable iff (!arst_n)
		mac_v_s2 |-> $past(ctl.op_sel == OP_MAC))
		else $error("accumulator fed by a scaling product");

	// A new result never overwrites one that is still waiting.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || result_ch.ready))
		else $error("result emitted over a pending result");

	// The last element of a run returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && ctl.last) |=> ctl.idle)
		else $error("sequencer busy after the last element of a run");

endmodule

### rtl/smv_ram.sv
// ----------------------------------------------------------------------------
// smv_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smv_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/smv_mul.sv
// ----------------------------------------------------------------------------
// smv_mul: shared signed multiplier
// Multiplies a wide signed operand by a signed value and registers the product.
// ----------------------------------------------------------------------------
module smv_mul import smv_pkg::*; (
	input  logic                         clk,
	input  logic signed [ACC_W-1:0]      op_a,
	input  logic signed [VALUE_BITS-1:0] op_b,
	output logic signed [PROD_W-1:0]     prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

endmodule

### rtl/smv_ctrl.sv
// ----------------------------------------------------------------------------
// smv_ctrl: sequencer of the scaled matrix-vector multiply
// Walks the y elements: for each, the dot product terms, then the alpha and
// beta scalings on the shared multiplier, then the emit; an empty A copies y.
// ----------------------------------------------------------------------------
module smv_ctrl import smv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t sts,
	output ctl_t    ctl
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] i_q, i_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic             k_last;
	logic             i_last;

	assign k_last = ({1'b0, k_q} == DIM_W'(sts.len_x - 1'b1));
	assign i_last = ({1'b0, i_q} == DIM_W'(sts.len_y - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		i_d            = i_q;
		k_d            = k_q;
		ctl            = '0;
		ctl.op_sel     = OP_MAC;
		ctl.y_idx      = i_q;
		ctl.x_idx      = k_q;
		ctl.last       = i_last;
		case (state_q)
			ST_IDLE: begin
				ctl.idle = 1'b1;
				if (sts.go && (sts.len_y != '0)) begin
					i_d         = '0;
					k_d         = '0;
					ctl.acc_clr = 1'b1;
					state_d     = sts.empty ? ST_YREAD : ST_MAC;
				end
			end
			ST_MAC: begin
				ctl.rd_issue = 1'b1;
				if (k_last) begin
					k_d     = '0;
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				ctl.op_sel = OP_ALPHA;
				state_d    = ST_BETA;
			end
			ST_BETA: begin
				ctl.op_sel     = OP_BETA;
				ctl.cap_scaled = 1'b1;
				state_d        = ST_SUM;
			end
			ST_SUM: begin
				ctl.cap_sum = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_YREAD: begin
				state_d = ST_YGET;
			end
			ST_YGET: begin
				ctl.cap_copy = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					if (i_last) begin
						state_d = ST_IDLE;
					end else begin
						i_d         = i_q + 1'b1;
						ctl.acc_clr = 1'b1;
						state_d     = sts.empty ? ST_YREAD : ST_MAC;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### tb/tb_scaled_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// tb_scaled_matrix_vector_multiply: self-checking bench for y = beta*y + alpha*op(A)*x
// Loads x, y and matrix elements and issues go items over the item channel.
// A built-in GEMV predictor works out every updated y element, and each
// result transfer is compared field by field with the oldest one pending.
// ----------------------------------------------------------------------------
module tb_scaled_matrix_vector_multiply;
	timeunit 1ns;
	timeprecision 1ps;

	import smv_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 5000;
	localparam int REPORT_LIMIT  = 10;

	localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = 16'sh7fff;
	localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = 16'sh8000;

	// One item as the bench builds it before driving the channel.
	typedef struct {
		logic [1:0]                   kind;
		logic [IDX_W-1:0]             vidx;
		logic [IDX_W-1:0]             row;
		logic [IDX_W-1:0]             col;
		logic signed [VALUE_BITS-1:0] value;
	} gemv_item_t;

	// One updated y element as it should leave the block.
	typedef struct {
		logic [IDX_W-1:0]             index;
		logic signed [VALUE_BITS-1:0] value;
		logic                         is_last;
	} y_elem_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [VALUE_BITS-1:0] cfg_wr_data;

	smv_item_if   item_ch ();
	smv_result_if result_ch ();

	scaled_matrix_vector_multiply dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_ch    (item_ch),
		.result_ch  (result_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	// Shadow copy of the configuration registers, kept in step with every write.
	logic                         cfg_transpose;
	logic [DIM_W-1:0]             cfg_rows;
	logic [DIM_W-1:0]             cfg_cols;
	logic signed [VALUE_BITS-1:0] cfg_alpha;
	logic signed [VALUE_BITS-1:0] cfg_beta;

	// Predictor copies of the three stores. The written flags let the bench
	// load every entry that a go item will read before that go is sent, since
	// the block's stores hold garbage until written.
	logic signed [VALUE_BITS-1:0] mat_vals [MAT_DEPTH];
	logic signed [VALUE_BITS-1:0] x_vals [MAX_DIM];
	logic signed [VALUE_BITS-1:0] y_vals [MAX_DIM];
	bit                           mat_written [MAT_DEPTH];
	bit                           x_written [MAX_DIM];
	bit                           y_written [MAX_DIM];

	// Updated y elements predicted but not yet seen on the result channel.
	y_elem_t     pending_y [$];

	int unsigned failures;
	int unsigned items_sent;
	int unsigned idle_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Vector lengths that the current configuration implies. Counts above
	// MAX_DIM are taken as MAX_DIM; a zero count on either side makes the
	// matrix empty, while y may still have a nonzero length.
	function automatic void effective_dims(output int unsigned len_x,
		output int unsigned len_y, output bit empty);
		int unsigned rows;
		int unsigned cols;
		rows = (cfg_rows > MAX_DIM) ? MAX_DIM : cfg_rows;
		cols = (cfg_cols > MAX_DIM) ? MAX_DIM : cfg_cols;
		if (cfg_transpose) begin
			len_y = cols;
			len_x = rows;
		end else begin
			len_y = rows;
			len_x = cols;
		end
		empty = (rows == 0) || (cols == 0);
	endfunction

	// Computes the whole updated y for a go item, writes it back into the y
	// copy and queues one expected element per y position.
	function automatic void predict_gemv();
		int unsigned                  len_x;
		int unsigned                  len_y;
		bit                           empty;
		longint                       dot;
		longint                       scaled;
		longint                       prior;
		longint                       total;
		logic signed [VALUE_BITS-1:0] a_val;
		logic signed [VALUE_BITS-1:0] new_y;
		y_elem_t                      elem;
		effective_dims(len_x, len_y, empty);
		for (int i = 0; i < len_y; i++) begin
			if (empty) begin
				// Nothing to multiply: y leaves unchanged, beta is not applied.
				new_y = y_vals[i];
			end else begin
				dot = 0;
				for (int k = 0; k < len_x; k++) begin
					a_val = cfg_transpose ? mat_vals[k * MAX_DIM + i] : mat_vals[i * MAX_DIM + k];
					dot += longint'(a_val) * longint'(x_vals[k]);
				end
				scaled = (dot * longint'(cfg_alpha)) >>> (2 * FRAC_BITS);
				prior = (cfg_beta == 0) ? 0 :
					(longint'(cfg_beta) * longint'(y_vals[i])) >>> FRAC_BITS;
				total = scaled + prior;
				if (total > longint'(VALUE_MAX))
					total = longint'(VALUE_MAX);
				else if (total < longint'(VALUE_MIN))
					total = longint'(VALUE_MIN);
				new_y = total[VALUE_BITS-1:0];
				y_vals[i] = new_y;
				y_written[i] = 1'b1;
			end
			elem.index = IDX_W'(i);
			elem.value = new_y;
			elem.is_last = (i + 1 == len_y);
			pending_y.push_back(elem);
		end
	endfunction

	// Applies one accepted item to the predictor. Fields that a kind does not
	// use are ignored, as the block must ignore them.
	function automatic void absorb_item(gemv_item_t it);
		case (it.kind)
			KIND_LOAD_X: begin
				x_vals[it.vidx] = it.value;
				x_written[it.vidx] = 1'b1;
			end
			KIND_LOAD_Y: begin
				y_vals[it.vidx] = it.value;
				y_written[it.vidx] = 1'b1;
			end
			KIND_LOAD_MAT: begin
				mat_vals[it.row * MAX_DIM + it.col] = it.value;
				mat_written[it.row * MAX_DIM + it.col] = 1'b1;
			end
			default: predict_gemv();
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	function automatic void note_failure(string msg);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	function automatic void check_y_elem();
		y_elem_t want;
		if (pending_y.size() == 0) begin
			note_failure($sformatf("unexpected result: index %0d value %0d last %0b",
				result_ch.result_index, result_ch.result_value, result_ch.last_of_run));
			return;
		end
		want = pending_y.pop_front();
		if (result_ch.result_index !== want.index)
			note_failure($sformatf("result_index: expected %0d, got %0d",
				want.index, result_ch.result_index));
		if (result_ch.result_value !== want.value)
			note_failure($sformatf("result_value at index %0d: expected %0d, got %0d",
				want.index, want.value, result_ch.result_value));
		if (result_ch.last_of_run !== want.is_last)
			note_failure($sformatf("last_of_run at index %0d: expected %0b, got %0b",
				want.index, want.is_last, result_ch.last_of_run));
	endfunction

	// The receiver samples at the rising edge, then picks its ready for the
	// next cycle. Stalls are random at the rate of the current phase.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			check_y_elem();
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// The watchdog ends a run that hangs: any transfer on either channel
	// restarts the count. The longest quiet stretch of a correct run is one
	// dot product plus a long receiver stall.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Small values four times in ten so that products stay in range, the rest full range
	// or at the extremes so that saturation is exercised too.
	function automatic logic signed [VALUE_BITS-1:0] random_value();
		case ($urandom_range(9))
			0: return VALUE_MAX;
			1: return VALUE_MIN;
			2, 3, 4, 5: return VALUE_BITS'(int'($urandom_range(0, 1023)) - 512);
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	function automatic gemv_item_t random_item();
		gemv_item_t it;
		it.kind = 2'($urandom);
		it.vidx = IDX_W'($urandom);
		it.row = IDX_W'($urandom);
		it.col = IDX_W'($urandom);
		it.value = VALUE_BITS'($urandom);
		return it;
	endfunction

	// Presents one item and holds it until the transfer. Valid stays high
	// after a transfer, so back-to-back items need no second assignment in
	// one time step; a sender gap lowers it first.
	task automatic send_item(input gemv_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= it.kind;
		item_ch.vector_index <= it.vidx;
		item_ch.matrix_row <= it.row;
		item_ch.matrix_column <= it.col;
		item_ch.element_value <= it.value;
		do
			@(posedge clk);
		while (!item_ch.ready);
		absorb_item(it);
		items_sent++;
	endtask

	// Loads one store entry; pos is the vector index or the matrix row, col
	// the matrix column. Fields the kind does not use carry random bits.
	task automatic load_entry(input logic [1:0] kind, input int unsigned pos,
		input int unsigned col, input logic signed [VALUE_BITS-1:0] value);
		gemv_item_t it;
		it = random_item();
		it.kind = kind;
		it.value = value;
		if (kind == KIND_LOAD_MAT) begin
			it.row = IDX_W'(pos);
			it.col = IDX_W'(col);
		end else begin
			it.vidx = IDX_W'(pos);
		end
		send_item(it);
	endtask

	task automatic send_go();
		gemv_item_t it;
		it = random_item();
		it.kind = KIND_GO;
		send_item(it);
	endtask

	// Loads, with random values, every entry that a go under the current
	// configuration reads and that was never written. y is read only when
	// beta is nonzero or when the matrix is empty.
	task automatic fill_operands();
		int unsigned len_x;
		int unsigned len_y;
		bit          empty;
		int unsigned r;
		int unsigned c;
		effective_dims(len_x, len_y, empty);
		for (int i = 0; i < len_y; i++) begin
			if (!y_written[i] && (empty || cfg_beta != 0))
				load_entry(KIND_LOAD_Y, i, 0, random_value());
			if (!empty) begin
				for (int k = 0; k < len_x; k++) begin
					r = cfg_transpose ? k : i;
					c = cfg_transpose ? i : k;
					if (!mat_written[r * MAX_DIM + c])
						load_entry(KIND_LOAD_MAT, r, c, random_value());
				end
			end
		end
		if (!empty) begin
			for (int k = 0; k < len_x; k++)
				if (!x_written[k])
					load_entry(KIND_LOAD_X, k, 0, random_value());
		end
	endtask

	// Stops sending and waits until every predicted y element has arrived,
	// then gives the block time to return to idle.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_y.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [VALUE_BITS-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		case (idx)
			CFG_TRANSPOSE: cfg_transpose = data[0];
			CFG_ROWS:      cfg_rows = data[DIM_W-1:0];
			CFG_COLS:      cfg_cols = data[DIM_W-1:0];
			CFG_ALPHA:     cfg_alpha = data;
			CFG_BETA:      cfg_beta = data;
			default: ;
		endcase
	endtask

	// Writes all five registers, only once the block has gone idle.
	task automatic set_config(input logic transpose, input int unsigned rows,
		input int unsigned cols, input logic signed [VALUE_BITS-1:0] alpha,
		input logic signed [VALUE_BITS-1:0] beta);
		wait_idle();
		write_register(CFG_TRANSPOSE, VALUE_BITS'(transpose));
		write_register(CFG_ROWS, VALUE_BITS'(rows));
		write_register(CFG_COLS, VALUE_BITS'(cols));
		write_register(CFG_ALPHA, alpha);
		write_register(CFG_BETA, beta);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset leaves both counts at zero, so a go produces no y at all.
	task automatic test_reset_state();
		send_go();
	endtask

	// A times x and its transpose with the operand extremes, plus loads at
	// the highest indexes that lie outside the region in use.
	task automatic test_plain_product();
		set_config(1'b0, 2, 3, ALPHA_RESET, 16'sd0);
		load_entry(KIND_LOAD_X, 0, 0, VALUE_MAX);
		load_entry(KIND_LOAD_X, 1, 0, VALUE_MIN);
		load_entry(KIND_LOAD_X, 2, 0, -16'sd1);
		load_entry(KIND_LOAD_X, 63, 0, 16'sd0);
		load_entry(KIND_LOAD_MAT, 0, 0, VALUE_MIN);
		load_entry(KIND_LOAD_MAT, 0, 1, VALUE_MAX);
		load_entry(KIND_LOAD_MAT, 0, 2, 16'sd256);
		load_entry(KIND_LOAD_MAT, 63, 63, -16'sd1);
		fill_operands();
		send_go();
		set_config(1'b1, 3, 2, ALPHA_RESET, 16'sd0);
		fill_operands();
		send_go();
	endtask

	// Extreme alpha and beta drive the sum into both saturation limits; the
	// last go uses alpha of zero with beta of one, which leaves y unchanged.
	task automatic test_scale_extremes();
		set_config(1'b0, 2, 2, VALUE_MIN, VALUE_MAX);
		load_entry(KIND_LOAD_Y, 0, 0, VALUE_MAX);
		load_entry(KIND_LOAD_Y, 1, 0, VALUE_MIN);
		load_entry(KIND_LOAD_X, 0, 0, VALUE_MAX);
		load_entry(KIND_LOAD_X, 1, 0, VALUE_MAX);
		load_entry(KIND_LOAD_MAT, 0, 0, VALUE_MAX);
		load_entry(KIND_LOAD_MAT, 0, 1, VALUE_MAX);
		load_entry(KIND_LOAD_MAT, 1, 0, VALUE_MIN);
		load_entry(KIND_LOAD_MAT, 1, 1, VALUE_MIN);
		send_go();
		set_config(1'b0, 2, 2, VALUE_MAX, VALUE_MIN);
		send_go();
		set_config(1'b0, 2, 2, 16'sd0, ALPHA_RESET);
		send_go();
	endtask

	// An empty matrix passes y through without beta; a zero y length gives
	// no result at all.
	task automatic test_empty_matrix();
		set_config(1'b1, 0, 3, 16'sd100, VALUE_MIN);
		fill_operands();
		send_go();
		set_config(1'b0, 0, 3, 16'sd100, VALUE_MIN);
		send_go();
	endtask

	// Counts above MAX_DIM act as MAX_DIM: the transpose of one matrix row
	// gives the longest y run, first without beta and then with it.
	task automatic test_count_clamp();
		set_config(1'b1, 1, 100, ALPHA_RESET, 16'sd0);
		fill_operands();
		send_go();
		set_config(1'b1, 1, 127, ALPHA_RESET, 16'sd128);
		fill_operands();
		send_go();
	endtask

	// Random rounds: an occasional new configuration, a few random loads
	// (mostly into the region in use, some anywhere as noise), the loads a go
	// still needs, then one or two go items. Now and then the sender waits
	// for every pending y element before the go.
	task automatic test_random_traffic(input int unsigned item_goal);
		int unsigned start_count;
		logic        transpose;
		int unsigned rows;
		int unsigned cols;
		logic signed [VALUE_BITS-1:0] alpha;
		logic signed [VALUE_BITS-1:0] beta;
		gemv_item_t  it;
		start_count = items_sent;
		while (items_sent - start_count < item_goal) begin
			if ($urandom_range(2) == 0) begin
				transpose = 1'($urandom);
				case ($urandom_range(9))
					0: begin
						// A column count of MAX_DIM or more over the first matrix row.
						transpose = 1'b1;
						rows = 1;
						cols = $urandom_range(64, 127);
					end
					1: begin
						rows = $urandom_range(1) ? 0 : $urandom_range(0, 5);
						cols = (rows == 0) ? $urandom_range(0, 5) : 0;
					end
					default: begin
						rows = $urandom_range(1, 6);
						cols = $urandom_range(1, 6);
					end
				endcase
				case ($urandom_range(5))
					0: alpha = VALUE_MIN;
					1: alpha = VALUE_MAX;
					2: alpha = ALPHA_RESET;
					3: alpha = 16'sd0;
					default: alpha = random_value();
				endcase
				case ($urandom_range(5))
					0, 1: beta = 16'sd0;
					2: beta = VALUE_MIN;
					3: beta = VALUE_MAX;
					default: beta = random_value();
				endcase
				set_config(transpose, rows, cols, alpha, beta);
			end
			repeat ($urandom_range(0, 6)) begin
				it = random_item();
				if (it.kind == KIND_GO)
					it.kind = KIND_LOAD_MAT;
				if ($urandom_range(9) < 7) begin
					it.vidx = IDX_W'($urandom_range(0, 7));
					it.row = IDX_W'($urandom_range(0, 7));
					it.col = IDX_W'($urandom_range(0, 7));
				end
				it.value = random_value();
				send_item(it);
			end
			fill_operands();
			if ($urandom_range(4) == 0)
				wait_idle();
			send_go();
			if ($urandom_range(3) == 0)
				send_go();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_TRANSPOSE;
		cfg_wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_LOAD_X;
		item_ch.vector_index = '0;
		item_ch.matrix_row = '0;
		item_ch.matrix_column = '0;
		item_ch.element_value = '0;
		result_ch.ready = 1'b0;
		cfg_transpose = 1'b0;
		cfg_rows = '0;
		cfg_cols = '0;
		cfg_alpha = ALPHA_RESET;
		cfg_beta = 16'sd0;
		failures = 0;
		items_sent = 0;
		idle_cycles = 0;

		// First phase: the sender idles now and then, the receiver mostly.
		send_idle_pct = 30;
		recv_idle_pct = 81;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_plain_product();
		test_scale_extremes();
		test_empty_matrix();
		test_count_clamp();
		test_random_traffic(20);

		// Second phase: the idle rates swap sides.
		send_idle_pct = 81;
		recv_idle_pct = 30;
		test_random_traffic(20);

		// Last phase: both sides run at full rate.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(20);

		// Drain every pending y element, then watch a while for strays.
		wait_idle();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
